### rtl/swp_pkg.sv
// Shared types and constants for the strided window pooling block.
`default_nettype none

package swp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_POOL_MODE   = 3'd0;
  localparam logic [2:0] CFG_WIN_ROWS    = 3'd1;
  localparam logic [2:0] CFG_WIN_COLS    = 3'd2;
  localparam logic [2:0] CFG_STRIDE_ROWS = 3'd3;
  localparam logic [2:0] CFG_STRIDE_COLS = 3'd4;
  localparam logic [2:0] CFG_IN_ROWS     = 3'd5;
  localparam logic [2:0] CFG_IN_COLS     = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int WIN_REG_W  = 4;
  localparam int SIZE_REG_W = 9;

  // Pooling modes
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT
  } swp_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_px;
    logic iter_init;
    logic row_step;
    logic col_step;
    logic mem_rd;
    logic mem_wr;
    logic div_start;
    logic out_load;
    logic pos_adv;
  } swp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic row_done;
    logic col_done;
    logic pair_ok;
    logic emit;
    logic avg_mode;
    logic div_busy;
    logic out_free;
  } swp_sts_t;

endpackage

`default_nettype wire

### rtl/swp_div.sv
// Serial restoring divider: signed dividend by unsigned divisor, truncated toward zero.
`default_nettype none

module swp_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 8
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  input  wire signed [NUM_W-1:0]  num,
  input  wire        [DEN_W-1:0]  den,
  output logic                    busy,
  output logic signed [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  // one quotient bit per cycle
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // magnitude shift register turns into the quotient
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      q_r   <= num[NUM_W-1] ? (~num + 1'b1) : num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
    end
  end

  assign busy = busy_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

`default_nettype wire

### rtl/swp_dp.sv
// Pooling datapath: position counters, window iterators, accumulator memory, output register.
`default_nettype none

module swp_dp #(
  parameter int MAX_IN_ROWS = 256,
  parameter int MAX_IN_COLS = 256,
  parameter int MAX_WIN     = 8,
  parameter int DATA_BITS   = 16,
  localparam int RW = (MAX_IN_ROWS > 1) ? $clog2(MAX_IN_ROWS) : 1,
  localparam int CW = (MAX_IN_COLS > 1) ? $clog2(MAX_IN_COLS) : 1,
  localparam int WW = $clog2(MAX_WIN + 1),
  localparam int PW = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         pool_mode,
  input  wire  [WW-1:0]               wr,
  input  wire  [WW-1:0]               wc,
  input  wire  [WW-1:0]               sr,
  input  wire  [WW-1:0]               sc,
  input  wire  [RW:0]                 rsize,
  input  wire  [CW:0]                 csize,
  input  wire                         pos_clear,
  input  wire signed [DATA_BITS-1:0]  in_pixel,
  input  swp_pkg::swp_cmd_t           cmd,
  output swp_pkg::swp_sts_t           sts,
  input  wire                         out_stall,
  output logic                        out_valid,
  output logic signed [DATA_BITS-1:0] out_pooled_value,
  output logic [PW-1:0]               out_peak_row,
  output logic [PW-1:0]               out_peak_col,
  output logic [RW-1:0]               out_row,
  output logic [CW-1:0]               out_col,
  output logic                        out_last_of_run
);

  localparam int DW    = $clog2(2 * MAX_WIN + 1);
  localparam int ACC_W = DATA_BITS + 2 * PW;
  localparam int AW    = 2 * WW;
  localparam int ENT_W = ACC_W + 2 * PW;
  localparam int AD_W  = RW + PW;
  localparam int DEPTH = 1 << AD_W;
  localparam int ER    = RW + 2;
  localparam int EC    = CW + 2;

  logic signed [DATA_BITS-1:0] px_r;

  // plane position and the last window start at or before it
  logic [RW-1:0] n_r, hi_r;
  logic [WW-1:0] r_r;
  logic [CW-1:0] m_r, khi_r;
  logic [WW-1:0] rc_r;

  // window iterators, walking downward from the newest window
  logic [RW-1:0] l_r, ls_r;
  logic [DW-1:0] dr_r;
  logic          rend_r;
  logic [CW-1:0] k_r, ks_r;
  logic [DW-1:0] dc_r;
  logic          cend_r;

  logic [ENT_W-1:0] acc_mem [DEPTH];
  logic [ENT_W-1:0] rd_ent_r;
  logic [AD_W-1:0]  addr;

  logic signed [ACC_W-1:0] px_ext, rd_val, nv;
  logic [PW-1:0]           npr, npc;
  logic                    first;

  logic signed [ACC_W-1:0] res_val_r;
  logic [PW-1:0]           res_pr_r, res_pc_r;
  logic [RW-1:0]           res_row_r;
  logic [CW-1:0]           res_col_r;

  logic row_ok, col_ok, row_over, col_over, row_hit, col_hit;
  logic out_valid_r, out_free;
  logic div_busy;
  logic signed [ACC_W-1:0] div_q;
  logic [AW-1:0] area;

  // window validity, completion and exhaustion
  assign row_ok   = (l_r == '0) ||
                    ((ER'(ls_r) + ER'(wr)) < (ER'(rsize) + ER'(sr)));
  assign col_ok   = (k_r == '0) ||
                    ((EC'(ks_r) + EC'(wc)) < (EC'(csize) + EC'(sc)));
  assign row_over = dr_r >= DW'(wr);
  assign col_over = dc_r >= DW'(wc);
  assign row_hit  = (dr_r == DW'(wr - 1'b1)) ||
                    (((ER'(ls_r) + ER'(wr)) > ER'(rsize)) &&
                     ((RW + 1)'(n_r) == rsize - 1'b1));
  assign col_hit  = (dc_r == DW'(wc - 1'b1)) ||
                    (((EC'(ks_r) + EC'(wc)) > EC'(csize)) &&
                     ((CW + 1)'(m_r) == csize - 1'b1));

  assign out_free = !out_valid_r || !out_stall;
  assign area     = AW'(wr) * AW'(wc);

  always_comb begin
    sts.row_done = rend_r || row_over || !col_ok;
    sts.col_done = cend_r || col_over;
    sts.pair_ok  = row_ok;
    sts.emit     = row_hit && col_hit;
    sts.avg_mode = pool_mode == swp_pkg::MODE_AVG;
    sts.div_busy = div_busy;
    sts.out_free = out_free;
  end

  // capture the pixel
  always_ff @(posedge clk) begin
    if (cmd.take_px) begin
      px_r <= in_pixel;
    end
  end

  // advance the plane position
  always_ff @(posedge clk) begin
    if (!rst_n || pos_clear) begin
      n_r   <= '0;
      hi_r  <= '0;
      r_r   <= '0;
      m_r   <= '0;
      khi_r <= '0;
      rc_r  <= '0;
    end else if (cmd.pos_adv) begin
      if ((RW + 1)'(n_r) + 1'b1 >= rsize) begin
        n_r  <= '0;
        hi_r <= '0;
        r_r  <= '0;
        if ((CW + 1)'(m_r) + 1'b1 >= csize) begin
          m_r   <= '0;
          khi_r <= '0;
          rc_r  <= '0;
        end else begin
          m_r <= m_r + 1'b1;
          if (rc_r + 1'b1 == sc) begin
            rc_r  <= '0;
            khi_r <= khi_r + 1'b1;
          end else begin
            rc_r <= rc_r + 1'b1;
          end
        end
      end else begin
        n_r <= n_r + 1'b1;
        if (r_r + 1'b1 == sr) begin
          r_r  <= '0;
          hi_r <= hi_r + 1'b1;
        end else begin
          r_r <= r_r + 1'b1;
        end
      end
    end
  end

  // step the row iterator; a column step restarts it
  always_ff @(posedge clk) begin
    if (cmd.iter_init || cmd.col_step) begin
      l_r    <= hi_r;
      ls_r   <= n_r - RW'(r_r);
      dr_r   <= DW'(r_r);
      rend_r <= 1'b0;
    end else if (cmd.row_step) begin
      if (l_r == '0) begin
        rend_r <= 1'b1;
      end else begin
        l_r  <= l_r - 1'b1;
        ls_r <= ls_r - RW'(sr);
        dr_r <= dr_r + DW'(sr);
      end
    end
  end

  // step the column iterator
  always_ff @(posedge clk) begin
    if (cmd.iter_init) begin
      k_r    <= khi_r;
      ks_r   <= m_r - CW'(rc_r);
      dc_r   <= DW'(rc_r);
      cend_r <= 1'b0;
    end else if (cmd.col_step) begin
      if (k_r == '0) begin
        cend_r <= 1'b1;
      end else begin
        k_r  <= k_r - 1'b1;
        ks_r <= ks_r - CW'(sc);
        dc_r <= dc_r + DW'(sc);
      end
    end
  end

  // accumulator entry for window (l, k mod power of two)
  assign addr = {l_r, PW'(k_r)};

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      acc_mem[addr] <= {nv, npr, npc};
    end
    if (cmd.mem_rd) begin
      rd_ent_r <= acc_mem[addr];
    end
  end

  // merge the pixel into the window
  always_comb begin
    px_ext = ACC_W'(px_r);
    rd_val = rd_ent_r[ENT_W-1 -: ACC_W];
    first  = (dr_r == '0) && (dc_r == '0);
    nv     = rd_val;
    npr    = rd_ent_r[2*PW-1 -: PW];
    npc    = rd_ent_r[PW-1:0];
    if (first) begin
      nv  = px_ext;
      npr = '0;
      npc = '0;
    end else if (pool_mode == swp_pkg::MODE_MAX) begin
      if (px_ext > rd_val) begin
        nv  = px_ext;
        npr = PW'(dr_r);
        npc = PW'(dc_r);
      end
    end else begin
      nv = rd_val + px_ext;
    end
  end

  // hold the finished window
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && sts.emit) begin
      res_val_r <= nv;
      res_pr_r  <= npr;
      res_pc_r  <= npc;
      res_row_r <= l_r;
      res_col_r <= k_r;
    end
  end

  swp_div #(
    .NUM_W (ACC_W),
    .DEN_W (AW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (nv),
    .den   (area),
    .busy  (div_busy),
    .quot  (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (pool_mode == swp_pkg::MODE_AVG) begin
        out_pooled_value <= div_q[DATA_BITS-1:0];
        out_peak_row     <= '0;
        out_peak_col     <= '0;
      end else begin
        out_pooled_value <= res_val_r[DATA_BITS-1:0];
        out_peak_row     <= res_pr_r;
        out_peak_col     <= res_pc_r;
      end
      out_row <= res_row_r;
      out_col <= res_col_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_last_of_run = 1'b1;

endmodule

`default_nettype wire

### rtl/swp_ctrl.sv
// Pooling controller: sequences window updates, division and result beats per pixel.
`default_nettype none

module swp_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  swp_pkg::swp_sts_t sts,
  output swp_pkg::swp_cmd_t cmd
);

  swp_pkg::swp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = swp_pkg::ST_SCAN;
      end
      swp_pkg::ST_SCAN: begin
        priority if (sts.col_done) state_nxt = swp_pkg::ST_IDLE;
        else if (sts.row_done)     state_nxt = swp_pkg::ST_SCAN;
        else if (sts.pair_ok)      state_nxt = swp_pkg::ST_UPDATE;
        else                       state_nxt = swp_pkg::ST_SCAN;
      end
      swp_pkg::ST_UPDATE: begin
        priority if (!sts.emit)  state_nxt = swp_pkg::ST_SCAN;
        else if (sts.avg_mode)   state_nxt = swp_pkg::ST_DIVIDE;
        else                     state_nxt = swp_pkg::ST_EMIT;
      end
      swp_pkg::ST_DIVIDE: begin
        if (!sts.div_busy) state_nxt = swp_pkg::ST_EMIT;
      end
      swp_pkg::ST_EMIT: begin
        if (sts.out_free) state_nxt = swp_pkg::ST_SCAN;
      end
      default: state_nxt = swp_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      swp_pkg::ST_IDLE: begin
        cmd.take_px   = in_valid;
        cmd.iter_init = in_valid;
      end
      swp_pkg::ST_SCAN: begin
        priority if (sts.col_done) cmd.pos_adv  = 1'b1;
        else if (sts.row_done)     cmd.col_step = 1'b1;
        else if (sts.pair_ok)      cmd.mem_rd   = 1'b1;
        else                       cmd.row_step = 1'b1;
      end
      swp_pkg::ST_UPDATE: begin
        cmd.mem_wr    = 1'b1;
        cmd.div_start = sts.emit && sts.avg_mode;
        cmd.row_step  = !sts.emit;
      end
      swp_pkg::ST_DIVIDE: begin
        cmd = '0;
      end
      swp_pkg::ST_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.row_step = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  assign in_stall = state_r != swp_pkg::ST_IDLE;

  // write back only the entry just read
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> $past(cmd.mem_rd))
    else $error("accumulator write without preceding read");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an unaccepted beat");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == swp_pkg::ST_SCAN))
    else $error("accepted pixel not scanned");

  a_update_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swp_pkg::ST_UPDATE) |-> ($past(state_r) == swp_pkg::ST_SCAN))
    else $error("update entered out of sequence");

endmodule

`default_nettype wire

### rtl/strided_window_pooling.sv
// Top level of the strided window pooling block: configuration registers and wiring.
`default_nettype none

// Pixels arrive one beat at a time in column-major order; the block works on one
// pixel at a time and stalls its input until that pixel is done. A pixel is first
// accepted, then scanned over each candidate window row and column step; every
// window it updates costs a read and a write back in the single-port accumulator
// memory, a window it completes adds an emit step, and in average mode the serial
// divider runs before the emit. The accumulator memory needs no clearing pass:
// every window entry is written by its first pixel. A result beat waits in an
// output register while the next pixel is already being processed. Any write to
// configuration indexes 0 to 6 restarts the plane.
module strided_window_pooling #(
  parameter int MAX_IN_ROWS = 256,
  parameter int MAX_IN_COLS = 256,
  parameter int MAX_WIN     = 8,
  parameter int DATA_BITS   = 16,
  localparam int RW = (MAX_IN_ROWS > 1) ? $clog2(MAX_IN_ROWS) : 1,
  localparam int CW = (MAX_IN_COLS > 1) ? $clog2(MAX_IN_COLS) : 1,
  localparam int PW = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [swp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [swp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire signed [DATA_BITS-1:0]           in_pixel,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [DATA_BITS-1:0]          out_pooled_value,
  output logic [PW-1:0]                        out_peak_row,
  output logic [PW-1:0]                        out_peak_col,
  output logic [RW-1:0]                        out_row,
  output logic [CW-1:0]                        out_col,
  output logic                                 out_last_of_run
);

  localparam int WW = $clog2(MAX_WIN + 1);

  logic                            pool_mode_r;
  logic [swp_pkg::WIN_REG_W-1:0]   win_rows_r, win_cols_r, stride_rows_r, stride_cols_r;
  logic [swp_pkg::SIZE_REG_W-1:0]  in_rows_r, in_cols_r;
  logic                            pos_clear;

  logic [WW-1:0] wr, wc, sr, sc;
  logic [RW:0]   rsize;
  logic [CW:0]   csize;

  swp_pkg::swp_cmd_t cmd;
  swp_pkg::swp_sts_t sts;

  // take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_mode_r   <= swp_pkg::MODE_MAX;
      win_rows_r    <= 4'd2;
      win_cols_r    <= 4'd2;
      stride_rows_r <= 4'd2;
      stride_cols_r <= 4'd2;
      in_rows_r     <= 9'd256;
      in_cols_r     <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swp_pkg::CFG_POOL_MODE:   pool_mode_r   <= cfg_data[0];
        swp_pkg::CFG_WIN_ROWS:    win_rows_r    <= cfg_data[swp_pkg::WIN_REG_W-1:0];
        swp_pkg::CFG_WIN_COLS:    win_cols_r    <= cfg_data[swp_pkg::WIN_REG_W-1:0];
        swp_pkg::CFG_STRIDE_ROWS: stride_rows_r <= cfg_data[swp_pkg::WIN_REG_W-1:0];
        swp_pkg::CFG_STRIDE_COLS: stride_cols_r <= cfg_data[swp_pkg::WIN_REG_W-1:0];
        swp_pkg::CFG_IN_ROWS:     in_rows_r     <= cfg_data[swp_pkg::SIZE_REG_W-1:0];
        swp_pkg::CFG_IN_COLS:     in_cols_r     <= cfg_data[swp_pkg::SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign pos_clear = cfg_we && (cfg_index <= swp_pkg::CFG_IN_COLS);

  // clamp registers into their working ranges
  always_comb begin
    wr = (win_rows_r == '0) ? WW'(1) :
         (win_rows_r > MAX_WIN) ? WW'(MAX_WIN) : WW'(win_rows_r);
    wc = (win_cols_r == '0) ? WW'(1) :
         (win_cols_r > MAX_WIN) ? WW'(MAX_WIN) : WW'(win_cols_r);
    sr = (stride_rows_r == '0) ? WW'(1) :
         (stride_rows_r > MAX_WIN) ? WW'(MAX_WIN) : WW'(stride_rows_r);
    sc = (stride_cols_r == '0) ? WW'(1) :
         (stride_cols_r > MAX_WIN) ? WW'(MAX_WIN) : WW'(stride_cols_r);
    rsize = (in_rows_r == '0) ? (RW + 1)'(1) :
            (in_rows_r > MAX_IN_ROWS) ? (RW + 1)'(MAX_IN_ROWS) : (RW + 1)'(in_rows_r);
    csize = (in_cols_r == '0) ? (CW + 1)'(1) :
            (in_cols_r > MAX_IN_COLS) ? (CW + 1)'(MAX_IN_COLS) : (CW + 1)'(in_cols_r);
  end

  swp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swp_dp #(
    .MAX_IN_ROWS (MAX_IN_ROWS),
    .MAX_IN_COLS (MAX_IN_COLS),
    .MAX_WIN     (MAX_WIN),
    .DATA_BITS   (DATA_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .pool_mode        (pool_mode_r),
    .wr               (wr),
    .wc               (wc),
    .sr               (sr),
    .sc               (sc),
    .rsize            (rsize),
    .csize            (csize),
    .pos_clear        (pos_clear),
    .in_pixel         (in_pixel),
    .cmd              (cmd),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_pooled_value (out_pooled_value),
    .out_peak_row     (out_peak_row),
    .out_peak_col     (out_peak_col),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

`default_nettype wire
